### src/sap_pkg.sv
// ============================================================================
// sap_pkg - shared types and constants of the stereo all-pass phaser
// Holds the sizes, the register indexes, the sequencer states and the
// command and status bundles that pass between the controller and datapath.
// ============================================================================
`default_nettype none

package sap_pkg;

	// Number of all-pass stages held per channel.
	localparam int MAX_STAGES  = 12;
	// Width of an audio sample on the ports.
	localparam int SAMPLE_BITS = 24;
	// Width of the saturating internal state.
	localparam int STATE_W     = 32;
	// Bits needed to index one stage.
	localparam int STAGE_W     = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALLPASS_COEF  = 3'd0,
		REG_FEEDBACK_GAIN = 3'd1,
		REG_STAGE_COUNT   = 3'd2,
		REG_WET_GAIN      = 3'd3,
		REG_DRY_GAIN      = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [16:0] allpass_coef;
		logic signed [15:0] feedback_gain;
		logic        [3:0]  stage_count;
		logic        [15:0] wet_gain;
		logic        [15:0] dry_gain;
	} cfg_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FB_MUL,
		ST_FB_ADD,
		ST_STG_MUL,
		ST_STG_ADD,
		ST_DRY_MUL,
		ST_WET_MUL,
		ST_MIX_SUM,
		ST_PUBLISH
	} state_t;

	// Datapath operations, one per cycle unless the sequencer idles or waits for the output register.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_FB_MUL,
		OP_FB_ADD,
		OP_STG_MUL,
		OP_STG_ADD,
		OP_DRY_MUL,
		OP_WET_MUL,
		OP_MIX_SUM,
		OP_PUBLISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t             op;
		logic               ch;       // 0 = left, 1 = right
		logic [STAGE_W-1:0] stage;
		logic               load_in;  // capture a new input sample pair
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;  // output register may be loaded this cycle
	} dp_sts_t;

endpackage

`default_nettype wire

### src/sap_cfg.sv
// ============================================================================
// sap_cfg - configuration registers
// Five write-only registers loaded from a plain write port. Writes to an
// index beyond the list are ignored.
// ============================================================================
`default_nettype none

module sap_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [sap_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [sap_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output sap_pkg::cfg_t                         cfg
);

	sap_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.allpass_coef  <= -17'sd61800;
			cfg_q.feedback_gain <= 16'sd0;
			cfg_q.stage_count   <= 4'd12;
			cfg_q.wet_gain      <= 16'd16384;
			cfg_q.dry_gain      <= 16'd16384;
		end else if (cfg_we) begin
			case (cfg_idx)
				sap_pkg::REG_ALLPASS_COEF:  cfg_q.allpass_coef  <= $signed(cfg_wdata[16:0]);
				sap_pkg::REG_FEEDBACK_GAIN: cfg_q.feedback_gain <= $signed(cfg_wdata[15:0]);
				sap_pkg::REG_STAGE_COUNT:   cfg_q.stage_count   <= cfg_wdata[3:0];
				sap_pkg::REG_WET_GAIN:      cfg_q.wet_gain      <= cfg_wdata[15:0];
				sap_pkg::REG_DRY_GAIN:      cfg_q.dry_gain      <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### src/sap_ctrl.sv
// ============================================================================
// sap_ctrl - sequencer of the phaser
// Steps the datapath through feedback, the all-pass stages and the mix for
// the left and then the right channel, and hands the result pair over.
// ============================================================================
`default_nettype none

module sap_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [3:0]          stage_count,
	input  wire sap_pkg::dp_sts_t    sts,
	output sap_pkg::dp_cmd_t         cmd
);

	sap_pkg::state_t                  state_q, state_d;
	logic                             ch_q, ch_d;
	logic [sap_pkg::STAGE_W-1:0]      stg_q, stg_d;
	logic [sap_pkg::STAGE_W-1:0]      last_idx;

	// Index of the last stage in use: zero stages count as one, and the
	// count is clipped to the stages that exist.
	always_comb begin
		if (stage_count == 4'd0) begin
			last_idx = '0;
		end else if (int'(stage_count) > sap_pkg::MAX_STAGES) begin
			last_idx = sap_pkg::STAGE_W'(sap_pkg::MAX_STAGES - 1);
		end else begin
			last_idx = sap_pkg::STAGE_W'(stage_count - 4'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sap_pkg::ST_IDLE;
			ch_q    <= 1'b0;
			stg_q   <= '0;
		end else begin
			state_q <= state_d;
			ch_q    <= ch_d;
			stg_q   <= stg_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ch_d        = ch_q;
		stg_d       = stg_q;
		cmd.op      = sap_pkg::OP_NONE;
		cmd.ch      = ch_q;
		cmd.stage   = stg_q;
		cmd.load_in = 1'b0;
		in_stall    = 1'b1;
		case (state_q)
			sap_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.load_in = in_valid;
				if (in_valid) begin
					ch_d    = 1'b0;
					state_d = sap_pkg::ST_FB_MUL;
				end
			end
			sap_pkg::ST_FB_MUL: begin
				cmd.op  = sap_pkg::OP_FB_MUL;
				state_d = sap_pkg::ST_FB_ADD;
			end
			sap_pkg::ST_FB_ADD: begin
				cmd.op  = sap_pkg::OP_FB_ADD;
				stg_d   = '0;
				state_d = sap_pkg::ST_STG_MUL;
			end
			sap_pkg::ST_STG_MUL: begin
				cmd.op  = sap_pkg::OP_STG_MUL;
				state_d = sap_pkg::ST_STG_ADD;
			end
			sap_pkg::ST_STG_ADD: begin
				cmd.op = sap_pkg::OP_STG_ADD;
				if (stg_q == last_idx) begin
					state_d = sap_pkg::ST_DRY_MUL;
				end else begin
					stg_d   = stg_q + 1'b1;
					state_d = sap_pkg::ST_STG_MUL;
				end
			end
			sap_pkg::ST_DRY_MUL: begin
				cmd.op  = sap_pkg::OP_DRY_MUL;
				state_d = sap_pkg::ST_WET_MUL;
			end
			sap_pkg::ST_WET_MUL: begin
				cmd.op  = sap_pkg::OP_WET_MUL;
				state_d = sap_pkg::ST_MIX_SUM;
			end
			sap_pkg::ST_MIX_SUM: begin
				cmd.op = sap_pkg::OP_MIX_SUM;
				if (ch_q == 1'b0) begin
					ch_d    = 1'b1;
					state_d = sap_pkg::ST_FB_MUL;
				end else begin
					state_d = sap_pkg::ST_PUBLISH;
				end
			end
			sap_pkg::ST_PUBLISH: begin
				if (sts.out_free) begin
					cmd.op  = sap_pkg::OP_PUBLISH;
					state_d = sap_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sap_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### src/sap_dp.sv
// ============================================================================
// sap_dp - datapath of the phaser
// One shared registered multiplier, the rounding and saturating adders, the
// per-stage state of both channels and the output register.
// ============================================================================
`default_nettype none

module sap_dp (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire sap_pkg::cfg_t                         cfg,
	input  wire sap_pkg::dp_cmd_t                      cmd,
	output sap_pkg::dp_sts_t                           sts,
	input  wire logic signed [sap_pkg::SAMPLE_BITS-1:0] left_in,
	input  wire logic signed [sap_pkg::SAMPLE_BITS-1:0] right_in,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [sap_pkg::SAMPLE_BITS-1:0]      left_out,
	output logic signed [sap_pkg::SAMPLE_BITS-1:0]      right_out
);

	localparam int SB     = sap_pkg::SAMPLE_BITS;
	localparam int SW     = sap_pkg::STATE_W;
	localparam int MA_W   = SW + 1;           // state difference
	localparam int MB_W   = 18;               // coefficient or gain
	localparam int PROD_W = MA_W + MB_W;
	localparam int SUM_W  = PROD_W + 1;

	localparam logic signed [SUM_W-1:0] ST_MAX  = (SUM_W'(1) <<< (SW - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] ST_MIN  = -ST_MAX - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] SMP_MAX = (SUM_W'(1) <<< (SB - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] SMP_MIN = -SMP_MAX - SUM_W'(1);

	// Shift right with rounding half toward plus infinity.
	function automatic logic signed [SUM_W-1:0] rnd_shift(
		input logic signed [SUM_W-1:0] v,
		input int unsigned             sh
	);
		logic signed [SUM_W-1:0] half;
		half = SUM_W'(1) <<< (sh - 1);
		return (v + half) >>> sh;
	endfunction

	function automatic logic signed [SW-1:0] sat_state(input logic signed [SUM_W-1:0] v);
		if (v > ST_MAX) begin
			return ST_MAX[SW-1:0];
		end else if (v < ST_MIN) begin
			return ST_MIN[SW-1:0];
		end
		return v[SW-1:0];
	endfunction

	function automatic logic signed [SB-1:0] sat_sample(input logic signed [SUM_W-1:0] v);
		if (v > SMP_MAX) begin
			return SMP_MAX[SB-1:0];
		end else if (v < SMP_MIN) begin
			return SMP_MIN[SB-1:0];
		end
		return v[SB-1:0];
	endfunction

	logic signed [SB-1:0]     in_q   [2];
	logic signed [SW-1:0]     last_q [2];
	logic signed [SW-1:0]     px_q   [2][sap_pkg::MAX_STAGES];
	logic signed [SW-1:0]     py_q   [2][sap_pkg::MAX_STAGES];
	logic signed [SW-1:0]     x_q;
	logic signed [PROD_W-1:0] p_q;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [SB-1:0]     res_l_q, res_r_q;
	logic signed [SB-1:0]     out_l_q, out_r_q;
	logic                     out_valid_q;

	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [SW-1:0]     px_rd, py_rd;
	logic signed [SUM_W-1:0]  in_ext, p_ext, acc_ext;
	logic signed [SW-1:0]     fb_x, stg_y;
	logic signed [SB-1:0]     mix_r;

	assign px_rd   = px_q[cmd.ch][cmd.stage];
	assign py_rd   = py_q[cmd.ch][cmd.stage];
	assign in_ext  = SUM_W'(in_q[cmd.ch]);
	assign p_ext   = SUM_W'(p_q);
	assign acc_ext = SUM_W'(acc_q);

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			sap_pkg::OP_FB_MUL: begin
				mul_a = MA_W'(last_q[cmd.ch]);
				mul_b = MB_W'(cfg.feedback_gain);
			end
			sap_pkg::OP_STG_MUL: begin
				mul_a = MA_W'(x_q) - MA_W'(py_rd);
				mul_b = MB_W'(cfg.allpass_coef);
			end
			sap_pkg::OP_DRY_MUL: begin
				mul_a = MA_W'(in_q[cmd.ch]);
				mul_b = $signed({2'b00, cfg.dry_gain});
			end
			sap_pkg::OP_WET_MUL: begin
				mul_a = MA_W'(x_q);
				mul_b = $signed({2'b00, cfg.wet_gain});
			end
			default: begin
			end
		endcase
	end

	assign fb_x  = sat_state(in_ext + rnd_shift(p_ext, 15));
	assign stg_y = sat_state(rnd_shift(p_ext, 16) + SUM_W'(px_rd));
	assign mix_r = sat_sample(rnd_shift(acc_ext + p_ext, 14));

	// Working registers; the payload needs no reset.
	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
		if (cmd.load_in) begin
			in_q[0] <= left_in;
			in_q[1] <= right_in;
		end
		case (cmd.op)
			sap_pkg::OP_FB_ADD:  x_q   <= fb_x;
			sap_pkg::OP_STG_ADD: x_q   <= stg_y;
			sap_pkg::OP_WET_MUL: acc_q <= p_q;
			sap_pkg::OP_MIX_SUM: begin
				if (cmd.ch) begin
					res_r_q <= mix_r;
				end else begin
					res_l_q <= mix_r;
				end
			end
			sap_pkg::OP_PUBLISH: begin
				out_l_q <= res_l_q;
				out_r_q <= res_r_q;
			end
			default: begin
			end
		endcase
	end

	// Filter state: cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 2; c++) begin
				last_q[c] <= '0;
				for (int s = 0; s < sap_pkg::MAX_STAGES; s++) begin
					px_q[c][s] <= '0;
					py_q[c][s] <= '0;
				end
			end
		end else begin
			case (cmd.op)
				sap_pkg::OP_STG_ADD: begin
					px_q[cmd.ch][cmd.stage] <= x_q;
					py_q[cmd.ch][cmd.stage] <= stg_y;
				end
				sap_pkg::OP_DRY_MUL: last_q[cmd.ch] <= x_q;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == sap_pkg::OP_PUBLISH) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign left_out     = out_l_q;
	assign right_out    = out_r_q;

endmodule

`default_nettype wire

### src/stereo_allpass_phaser.sv
// The work per input transaction grows with N, the number of stages in use
// (1 to 12). A new sample pair is taken only once the last one has been moved
// into the output register. The single shared multiplier is used for the
// feedback, every stage, the dry and the wet product of each channel.
// Reset: arst_n clears all stage state, the chain feedback and the output
// valid, and loads the register defaults; the block is ready at once.
// ============================================================================
// stereo_allpass_phaser - stereo first-order all-pass phaser with feedback
// Runs each channel through a chain of identical first-order all-pass
// stages with feedback from the chain output, and mixes dry and wet signals.
// ============================================================================
`default_nettype none

module stereo_allpass_phaser (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// Configuration write port.
	input  wire logic                                   cfg_we,
	input  wire logic [sap_pkg::CFG_IDX_W-1:0]          cfg_idx,
	input  wire logic [sap_pkg::CFG_DATA_W-1:0]         cfg_wdata,
	// Input channel.
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [sap_pkg::SAMPLE_BITS-1:0] left_in,
	input  wire logic signed [sap_pkg::SAMPLE_BITS-1:0] right_in,
	// Output channel.
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [sap_pkg::SAMPLE_BITS-1:0]      left_out,
	output logic signed [sap_pkg::SAMPLE_BITS-1:0]      right_out
);

	// The configuration registers feed both the sequencer, which needs the
	// stage count, and the datapath, which needs the coefficient and gains.
	// Registers are expected to change only while no transaction is in flight.
	sap_pkg::cfg_t    cfg;
	sap_pkg::dp_cmd_t cmd;
	sap_pkg::dp_sts_t sts;

	sap_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// The sequencer takes one input transaction at a time. For each channel,
	// left first, it issues: the feedback product and its sum with the input,
	// then a multiply and an add per stage, then the dry and wet products and
	// their rounded, saturated sum. Finally it moves the result pair into the
	// output register as soon as that register is free. Because the output
	// register stands apart, the block returns to idle and takes the next
	// input transaction while a finished result still waits downstream.
	sap_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.stage_count (cfg.stage_count),
		.sts         (sts),
		.cmd         (cmd)
	);

	// The datapath holds the per-stage last input and output of both channels
	// and the last chain output used for feedback. Every product is registered
	// before the rounding adder that follows it, so only one multiply or one
	// wide add and saturate sits between registers.
	sap_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.left_in   (left_in),
		.right_in  (right_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.left_out  (left_out),
		.right_out (right_out)
	);

endmodule

`default_nettype wire
